FILE: design/tfsg_pkg.sv
// Shared types, constants and helpers of the TCP flow sequence gap detector.
// Depends on nothing; every other file imports it.
package tfsg_pkg;

  localparam int FLOW_ENTRIES_DEF = 64;
  localparam int KEY_W            = 96;
  localparam int SEQ_W            = 32;

  localparam logic [SEQ_W-1:0] GAP_LIMIT_RST = 32'd16777216;

  // One TCP/IPv4 segment header.
  typedef struct packed {
    logic        is_tcp_ipv4;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_tcp_port;
    logic [15:0] dst_tcp_port;
    logic [31:0] seq_num;
    logic [15:0] payload_len;
    logic        syn_bit;
    logic        fin_bit;
  } seg_t;

  // One result item.
  typedef struct packed {
    logic        gap_found;
    logic [31:0] gap_size;
    logic        new_flow;
    logic        table_full;
    logic        ignored;
  } res_t;

  // What travels from cell to cell with each segment.
  typedef struct packed {
    logic             valid;
    logic             tcp;
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] seq_end;
    logic             hit;      // matched a stored flow
    logic             created;  // claimed a free entry
    logic             ahead;    // start at or ahead of the stored highest end
    logic [SEQ_W-1:0] gap;      // start minus stored highest end
  } beat_t;

  // Wrap-aware order: a is at or ahead of b when a - b lies in the lower half.
  function automatic logic seq_at_or_ahead(input logic [SEQ_W-1:0] a,
                                           input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] diff;
    diff = a - b;
    return ~diff[SEQ_W-1];
  endfunction

endpackage

FILE: design/tfsg_ifs.sv
// Valid/ready channel interfaces for segment headers and results.
// Depends on tfsg_pkg for the payload types.
interface tfsg_seg_if import tfsg_pkg::*; ();
  logic valid;
  logic ready;
  seg_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tfsg_res_if import tfsg_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/tfsg_cell.sv
// One flow table cell: holds one entry and one pipeline stage of the segment chain.
// Depends on tfsg_pkg.
module tfsg_cell import tfsg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  beat_t beat_in,
  output beat_t beat_out
);

  logic             entry_valid;
  logic [KEY_W-1:0] entry_key;
  logic [SEQ_W-1:0] highest_end;
  beat_t            beat_q;

  logic             act;
  logic             match;
  logic             claim;
  logic [SEQ_W-1:0] diff;
  logic             start_ahead;
  logic             end_ahead;
  beat_t            beat_next;

  // Entries fill from the low end and are never freed, so the first empty
  // cell that an unmatched segment reaches is the lowest free entry.
  assign act         = beat_in.valid && beat_in.tcp && !beat_in.hit && !beat_in.created;
  assign match       = act && entry_valid && (entry_key == beat_in.key);
  assign claim       = act && !entry_valid;
  assign diff        = beat_in.seq - highest_end;
  assign start_ahead = ~diff[SEQ_W-1];
  assign end_ahead   = seq_at_or_ahead(beat_in.seq_end, highest_end);

  always_comb begin
    beat_next = beat_in;
    if (match) begin
      beat_next.hit   = 1'b1;
      beat_next.ahead = start_ahead;
      beat_next.gap   = diff;
    end
    if (claim) begin
      beat_next.created = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= 1'b0;
      beat_q.valid <= 1'b0;
    end else if (adv) begin
      beat_q <= beat_next;
      if (claim) begin
        entry_valid <= 1'b1;
        entry_key   <= beat_in.key;
        highest_end <= beat_in.seq_end;
      end else if (match && (start_ahead || end_ahead)) begin
        highest_end <= beat_in.seq_end;
      end
    end
  end

  assign beat_out = beat_q;

endmodule

FILE: design/tfsg_result.sv
// Output stage: turns the beat leaving the cell chain into a result and holds it.
// Depends on tfsg_pkg and tfsg_res_if.
module tfsg_result import tfsg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  beat_t            last,
  input  logic [SEQ_W-1:0] gap_limit,
  output logic             adv,
  tfsg_res_if.source       res
);

  res_t res_next;
  logic gap_ok;

  assign adv    = !res.valid || res.ready;
  assign gap_ok = last.hit && last.ahead && (last.gap != '0) && (last.gap < gap_limit);

  always_comb begin
    res_next            = '0;
    res_next.ignored    = !last.tcp;
    res_next.new_flow   = last.tcp && last.created;
    res_next.table_full = last.tcp && !last.hit && !last.created;
    res_next.gap_found  = last.tcp && gap_ok;
    res_next.gap_size   = (last.tcp && gap_ok) ? last.gap : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= last.valid;
      res.data  <= res_next;
    end
  end

endmodule

FILE: design/tcp_flow_seq_gap_detector.sv
// Top level of the TCP flow sequence gap detector: gap limit register, cell chain, output.
// Depends on tfsg_pkg, tfsg_ifs, tfsg_cell and tfsg_result.

// Each segment header walks a row of FLOW_ENTRIES cells and then the result
// register, and every cell holds one flow entry. One beat can enter every
// cycle while no result waits on the output, so the sustained rate is then
// one item per cycle. The whole chain moves together and halts while a result
// waits on the output; the flow table needs no clearing pass after reset. A
// segment from a flow that is not yet stored takes the lowest free entry; once
// all entries are in use, new flows are reported as table_full and not stored.
// gap_limit is written through cfg_wr_en and cfg_wr_data; the user must write
// it only while no beats are in flight, as the block itself does not enforce it.
module tcp_flow_seq_gap_detector import tfsg_pkg::*; #(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tfsg_seg_if.sink    seg,
  tfsg_res_if.source  res,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [SEQ_W-1:0] gap_limit;
  logic             adv;
  beat_t            chain [FLOW_ENTRIES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= GAP_LIMIT_RST;
    end else if (cfg_wr_en) begin
      gap_limit <= cfg_wr_data;
    end
  end

  assign seg.ready = adv;

  always_comb begin
    chain[0]         = '0;
    chain[0].valid   = seg.valid;
    chain[0].tcp     = seg.data.is_tcp_ipv4;
    chain[0].key     = {seg.data.src_ip, seg.data.dst_ip,
                        seg.data.src_tcp_port, seg.data.dst_tcp_port};
    chain[0].seq     = seg.data.seq_num;
    chain[0].seq_end = seg.data.seq_num + {16'b0, seg.data.payload_len}
                       + {31'b0, seg.data.syn_bit} + {31'b0, seg.data.fin_bit};
  end

  for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
    tfsg_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  tfsg_result u_result (
    .clk       (clk),
    .rst       (rst),
    .last      (chain[FLOW_ENTRIES]),
    .gap_limit (gap_limit),
    .adv       (adv),
    .res       (res)
  );

endmodule

FILE: design/tfsg_checker.sv
// Port-level checks on the results of the TCP flow sequence gap detector.
// Depends on tfsg_pkg; bound to tcp_flow_seq_gap_detector below.
module tfsg_checker import tfsg_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res_data
);

  // A result names at most one outcome.
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ($countones({res_data.gap_found, res_data.new_flow,
                               res_data.table_full, res_data.ignored}) <= 1))
    else $error("result carries more than one outcome");

  a_no_gap_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.gap_found) |-> (res_data.gap_size == '0))
    else $error("gap_size set without gap_found");

  a_gap_nonzero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.gap_found) |-> (res_data.gap_size != '0))
    else $error("gap reported with zero size");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("stalled result changed");

endmodule

bind tcp_flow_seq_gap_detector tfsg_checker u_tfsg_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);
